// File: hw/rtl/fla_pkg.sv
`default_nettype none
package fla_pkg;

  localparam int SLOT_COUNT = 128;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_W      = 8;
  localparam int LINK_W     = 8;
  localparam int BLOCK_W    = 13;
  localparam int OFFSET_W   = 19;
  localparam int PROD_W     = SLOT_W + BLOCK_W;

  localparam logic [LINK_W-1:0]  LINK_END        = '1;
  localparam logic [BLOCK_W-1:0] MIN_BLOCK_BYTES = BLOCK_W'(4);
  localparam logic [BLOCK_W-1:0] BLOCK_RESET     = BLOCK_W'(4);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WAIT = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot_index;
    logic             null_ref;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   granted_index;
    logic [OFFSET_W-1:0] byte_offset;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic res_push;
    logic cmd_pop;
  } bk_stat_t;

  // link value of a slot that was never written since reset
  function automatic logic [LINK_W-1:0] default_link(input logic [SLOT_W-1:0] s);
    logic [LINK_W-1:0] nxt;
    nxt = LINK_W'(s) + LINK_W'(1);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? LINK_END : nxt;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fla_front.sv
`default_nettype none
module fla_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire fla_pkg::in_item_t in_item,
  output logic                 in_full,
  output logic                 cmd_valid,
  output fla_pkg::cmd_t        cmd,
  input  wire logic            cmd_pop
);
  import fla_pkg::*;

  cmd_t       cq_r [2];
  logic       cq_wptr_r, cq_rptr_r;
  logic [1:0] cq_cnt_r;
  cmd_t       cls;
  logic       do_push, do_pop;

  // classify: rejects carry their status, so the back end only forwards them
  always_comb begin
    cls.kind   = CMD_ALLOC;
    cls.status = ST_OK;
    cls.slot   = in_item.slot_index[SLOT_W-1:0];
    if (in_item.op == OP_FREE) begin
      if (in_item.null_ref) begin
        cls.kind   = CMD_REJECT;
        cls.status = ST_NULL;
      end else if ({1'b0, in_item.slot_index} >= (IDX_W+1)'(SLOT_COUNT)) begin
        cls.kind   = CMD_REJECT;
        cls.status = ST_RANGE;
      end else begin
        cls.kind = CMD_FREE;
      end
    end
  end

  assign in_full   = (cq_cnt_r == 2'd2);
  assign cmd_valid = (cq_cnt_r != 2'd0);
  assign cmd       = cq_r[cq_rptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wptr_r <= 1'b0;
      cq_rptr_r <= 1'b0;
      cq_cnt_r  <= 2'd0;
    end else begin
      if (do_push) cq_wptr_r <= !cq_wptr_r;
      if (do_pop) cq_rptr_r <= !cq_rptr_r;
      cq_cnt_r <= cq_cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) cq_r[cq_wptr_r] <= cls;
  end

endmodule
`default_nettype wire

// File: hw/rtl/fla_back.sv
`default_nettype none
module fla_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [fla_pkg::BLOCK_W-1:0]   block_bytes,
  input  wire logic                          cmd_valid,
  input  wire fla_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  output logic                               out_empty,
  output fla_pkg::out_item_t                 out_item,
  input  wire logic                          out_pop,
  output fla_pkg::bk_stat_t                  stat
);
  import fla_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] link_mem_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [LINK_W-1:0] rd_data_r;
  logic              rd_valid_r;

  out_item_t         oq_r [2];
  logic              oq_wptr_r, oq_rptr_r;
  logic [1:0]        oq_cnt_r;

  logic              has_space, head_ok;
  logic [SLOT_W-1:0] head_slot;
  logic              mem_we, mem_re, res_push, oq_pop;
  out_item_t         res;
  logic [BLOCK_W-1:0] bs;
  logic [PROD_W-1:0] prod;
  logic [LINK_W-1:0] link;

  assign has_space = (oq_cnt_r != 2'd2);
  assign head_ok   = (head_r < LINK_W'(SLOT_COUNT));
  assign head_slot = head_r[SLOT_W-1:0];
  assign bs        = (block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes;
  assign prod      = PROD_W'(head_slot) * PROD_W'(bs);
  // unwritten entries fall back to their reset link
  assign link      = rd_valid_r ? rd_data_r : default_link(head_slot);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && has_space && cmd.kind == CMD_ALLOC && head_ok) state_nxt = BK_WAIT;
      end
      BK_WAIT: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_push = 1'b0;
    head_nxt = head_r;
    res.status        = ST_OK;
    res.granted_index = '0;
    res.byte_offset   = '0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && has_space) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_ALLOC: begin
              if (head_ok) begin
                mem_re = 1'b1;
              end else begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
              end
            end
            CMD_FREE: begin
              mem_we   = 1'b1;
              head_nxt = LINK_W'(cmd.slot);
              res_push = 1'b1;
            end
            default: begin
              res_push   = 1'b1;
              res.status = cmd.status;
            end
          endcase
        end
      end
      BK_WAIT: begin
        res_push          = 1'b1;
        res.granted_index = head_slot;
        res.byte_offset   = prod[OFFSET_W-1:0];
        head_nxt          = link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      head_r     <= '0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      if (mem_we) valid_r[cmd.slot] <= 1'b1;
      if (mem_re) rd_valid_r <= valid_r[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem_r[cmd.slot] <= head_r;
    if (mem_re) rd_data_r <= link_mem_r[head_slot];
  end

  // result queue
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_item  = oq_r[oq_rptr_r];
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= 1'b0;
      oq_rptr_r <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      if (res_push) oq_wptr_r <= !oq_wptr_r;
      if (oq_pop) oq_rptr_r <= !oq_rptr_r;
      oq_cnt_r <= oq_cnt_r + 2'(res_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oq_r[oq_wptr_r] <= res;
  end

  assign stat.busy     = (state_r == BK_WAIT);
  assign stat.res_push = res_push;
  assign stat.cmd_pop  = cmd_pop;

endmodule
`default_nettype wire

// File: hw/rtl/free_list_block_allocator_unit.sv
`default_nettype none
// Free-list slot allocator for a pool of 128 equal-size blocks.
// Input queue port: present an item on in_item with in_push while in_full is
// low. op ALLOC pops the head slot; op FREE pushes slot_index back (null or
// out-of-range frees are rejected with a status and change nothing).
// Result queue port: out_item holds the oldest result while out_empty is low;
// out_pop takes it. Every item yields exactly one result, in order.
// cfg_we/cfg_wdata write the block size (bytes) used to scale byte_offset;
// write it only while no items are in flight.
// Order: a free or rejected command writes its result into the result queue
// when the back end takes it; a successful allocate first reads the next link
// and writes its result from the WAIT state.
// Throughput: frees and rejects 1 item per cycle while results drain; an
// allocate blocks the next command until its next-link read sets the head.
// Reset: head is slot 0, links read as i+1 through per-slot valid bits cleared
// at once (no init pass; last slot: end mark), block size 4. Both queues empty.
// A stalled result side fills a 2-deep result queue, then a 2-deep command
// queue, then raises in_full; nothing is dropped.
module free_list_block_allocator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire fla_pkg::in_item_t             in_item,
  output logic                               in_full,
  output logic                               out_empty,
  output fla_pkg::out_item_t                 out_item,
  input  wire logic                          out_pop,
  input  wire logic                          cfg_we,
  input  wire logic [fla_pkg::BLOCK_W-1:0]   cfg_wdata
);
  import fla_pkg::*;

  logic [BLOCK_W-1:0] block_bytes_r;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;
  bk_stat_t           bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BLOCK_RESET;
    end else if (cfg_we) begin
      block_bytes_r <= cfg_wdata;
    end
  end

  fla_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fla_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .block_bytes (block_bytes_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_empty   (out_empty),
    .out_item    (out_item),
    .out_pop     (out_pop),
    .stat        (bk_stat)
  );

  // no new command while a link read is outstanding
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !bk_stat.cmd_pop)
    else $error("command taken during link read");

  // busy always drops right after a link read, which produces a result
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |=> !bk_stat.busy)
    else $error("link read wait exceeded one cycle");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> bk_stat.res_push)
    else $error("allocate finished without a result");

  // a full command queue always offers work to the back end
  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> cmd_valid)
    else $error("command queue full but empty");

endmodule
`default_nettype wire
